### rtl/cmcb_pkg.sv
// ----------------------------------------------------------------------------
// cmcb_pkg
// Shared types and constants of the colour-key sprite blitter.
// ----------------------------------------------------------------------------
package cmcb_pkg;

    localparam int COORD_BITS = 12;
    localparam int LCOORD_W   = COORD_BITS - 1;
    localparam int DCOORD_W   = COORD_BITS + 2;
    localparam int INDEX_W    = 2 * COORD_BITS - 2;
    localparam int PIXEL_W    = 8;
    localparam int MODE_W     = 2;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam int MIRROR_H_BIT = 0;
    localparam int MIRROR_V_BIT = 1;

    localparam logic [REG_IDX_W-1:0] REG_CLIP_LEFT    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_TOP     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DEST_WIDTH   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TRANSPARENT  = 3'd6;

    localparam logic [LCOORD_W-1:0]   CLIP_LEFT_RST    = '0;
    localparam logic [LCOORD_W-1:0]   CLIP_TOP_RST     = '0;
    localparam logic [COORD_BITS-1:0] CLIP_RIGHT_RST   = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0] CLIP_BOTTOM_RST  = COORD_BITS'(200);
    localparam logic [COORD_BITS-1:0] SOURCE_WIDTH_RST = COORD_BITS'(747);
    localparam logic [COORD_BITS-1:0] DEST_WIDTH_RST   = COORD_BITS'(320);
    localparam logic [PIXEL_W-1:0]    TRANSPARENT_RST  = '0;

    typedef struct packed {
        logic                         start_req;
        logic signed [COORD_BITS-1:0] dest_x;
        logic signed [COORD_BITS-1:0] dest_y;
        logic [LCOORD_W-1:0]          src_left;
        logic [LCOORD_W-1:0]          src_top;
        logic [COORD_BITS-1:0]        src_right;
        logic [COORD_BITS-1:0]        src_bottom;
        logic [MODE_W-1:0]            mirror_mode;
        logic [PIXEL_W-1:0]           pixel;
    } cmcb_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] source_index;
        logic [INDEX_W-1:0] dest_index;
        logic               write_enable;
        logic [PIXEL_W-1:0] pixel_out;
        logic               last;
    } cmcb_out_t;

    function automatic logic signed [DCOORD_W-1:0] sext_coord(
        input logic signed [COORD_BITS-1:0] v
    );
        return DCOORD_W'(v);
    endfunction

endpackage

### rtl/cmcb_if.sv
// ----------------------------------------------------------------------------
// cmcb_in_if / cmcb_out_if
// Valid/ready channels carrying blitter requests and results.
// ----------------------------------------------------------------------------
interface cmcb_in_if
    import cmcb_pkg::*;
();
    logic     valid;
    logic     ready;
    cmcb_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cmcb_out_if
    import cmcb_pkg::*;
();
    logic      valid;
    logic      ready;
    cmcb_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/clipped_mirrored_colorkey_blit.sv
// ----------------------------------------------------------------------------
// clipped_mirrored_colorkey_blit
// Colour-key sprite blitter pixel engine with clipping and mirroring.
// ----------------------------------------------------------------------------
// One request per source pixel, one result per request, one request per clock
// sustained while results are taken. A request with start_req latches the blit
// geometry and carries the first pixel; later requests carry the pixels in
// mirrored walk order. A taken request is registered in the first stage and
// its result in the second: the first stage walks the cursors and does the clip
// and key tests, the second forms both linear indices with one 12x12 multiply
// each. Clip, pitch and key registers must be written over the APB port only
// while no requests are in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module clipped_mirrored_colorkey_blit
    import cmcb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    cmcb_in_if.sink            item,
    cmcb_out_if.source         result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    typedef struct packed {
        logic [COORD_BITS-1:0] src_row;
        logic [COORD_BITS-1:0] src_col;
        logic [COORD_BITS-1:0] dst_row;
        logic [COORD_BITS-1:0] dst_col;
        logic                  we;
        logic [PIXEL_W-1:0]    pix;
        logic                  last;
    } s1_t;

    // configuration
    logic [LCOORD_W-1:0]   clip_left_reg, clip_top_reg;
    logic [COORD_BITS-1:0] clip_right_reg, clip_bottom_reg;
    logic [COORD_BITS-1:0] source_width_reg, dest_width_reg;
    logic [PIXEL_W-1:0]    transparent_reg;
    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  cfg_idx;

    // blit state
    logic signed [DCOORD_W-1:0] origin_col_reg, dst_col_reg, dst_row_reg;
    logic signed [DCOORD_W-1:0] origin_col_next, dst_col_next, dst_row_next;
    logic [COORD_BITS-1:0]      src_col_reg, src_row_reg, src_col_next, src_row_next;
    logic [LCOORD_W-1:0]        rect_l_reg, rect_t_reg, rect_l_next, rect_t_next;
    logic [COORD_BITS-1:0]      rect_r_reg, rect_b_reg, rect_r_next, rect_b_next;
    logic [MODE_W-1:0]          mode_reg, mode_next;
    logic                       busy_reg, busy_next;

    // pipeline
    logic      s1_valid_reg;
    s1_t       s1_reg, s1_next;
    logic      res_valid_reg;
    cmcb_out_t res_reg;
    logic      res_load, s1_ready, item_fire;

    // walk terms
    logic                       start, empty, active, hmir, vmir;
    logic                       col_end, row_end, in_clip, we;
    logic [MODE_W-1:0]          act_mode;
    logic [LCOORD_W-1:0]        act_l, act_t;
    logic [COORD_BITS-1:0]      act_r, act_b, act_scol, act_srow;
    logic signed [DCOORD_W-1:0] act_dcol, act_drow, act_origin;

    // index terms
    logic [2*COORD_BITS-1:0] sprod, dprod, sidx, didx;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg    <= CLIP_LEFT_RST;
            clip_top_reg     <= CLIP_TOP_RST;
            clip_right_reg   <= CLIP_RIGHT_RST;
            clip_bottom_reg  <= CLIP_BOTTOM_RST;
            source_width_reg <= SOURCE_WIDTH_RST;
            dest_width_reg   <= DEST_WIDTH_RST;
            transparent_reg  <= TRANSPARENT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_CLIP_LEFT:    clip_left_reg    <= pwdata[LCOORD_W-1:0];
                REG_CLIP_TOP:     clip_top_reg     <= pwdata[LCOORD_W-1:0];
                REG_CLIP_RIGHT:   clip_right_reg   <= pwdata[COORD_BITS-1:0];
                REG_CLIP_BOTTOM:  clip_bottom_reg  <= pwdata[COORD_BITS-1:0];
                REG_SOURCE_WIDTH: source_width_reg <= pwdata[COORD_BITS-1:0];
                REG_DEST_WIDTH:   dest_width_reg   <= pwdata[COORD_BITS-1:0];
                REG_TRANSPARENT:  transparent_reg  <= pwdata[PIXEL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            REG_CLIP_LEFT:    prdata[LCOORD_W-1:0]   = clip_left_reg;
            REG_CLIP_TOP:     prdata[LCOORD_W-1:0]   = clip_top_reg;
            REG_CLIP_RIGHT:   prdata[COORD_BITS-1:0] = clip_right_reg;
            REG_CLIP_BOTTOM:  prdata[COORD_BITS-1:0] = clip_bottom_reg;
            REG_SOURCE_WIDTH: prdata[COORD_BITS-1:0] = source_width_reg;
            REG_DEST_WIDTH:   prdata[COORD_BITS-1:0] = dest_width_reg;
            REG_TRANSPARENT:  prdata[PIXEL_W-1:0]    = transparent_reg;
            default:          prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign res_load   = !res_valid_reg || result.ready;
    assign s1_ready   = !s1_valid_reg || res_load;
    assign item.ready = s1_ready;
    assign item_fire  = item.valid && s1_ready;

    // ---------------- stage 1: walk, clip, key ----------------
    always_comb
    begin
        start    = item.data.start_req;
        empty    = (item.data.src_right <= {1'b0, item.data.src_left}) ||
                   (item.data.src_bottom <= {1'b0, item.data.src_top});
        act_mode = start ? item.data.mirror_mode : mode_reg;
        hmir     = act_mode[MIRROR_H_BIT];
        vmir     = act_mode[MIRROR_V_BIT];
        act_l    = start ? item.data.src_left   : rect_l_reg;
        act_t    = start ? item.data.src_top    : rect_t_reg;
        act_r    = start ? item.data.src_right  : rect_r_reg;
        act_b    = start ? item.data.src_bottom : rect_b_reg;
        active   = start ? !empty : busy_reg;

        if (start)
        begin
            act_scol   = hmir ? act_r - 1'b1 : {1'b0, act_l};
            act_srow   = vmir ? act_b - 1'b1 : {1'b0, act_t};
            act_origin = sext_coord(item.data.dest_x);
            act_dcol   = sext_coord(item.data.dest_x);
            act_drow   = sext_coord(item.data.dest_y);
        end
        else
        begin
            act_scol   = src_col_reg;
            act_srow   = src_row_reg;
            act_origin = origin_col_reg;
            act_dcol   = dst_col_reg;
            act_drow   = dst_row_reg;
        end

        col_end = hmir ? (act_scol == {1'b0, act_l}) : (act_scol == act_r - 1'b1);
        row_end = vmir ? (act_srow == {1'b0, act_t}) : (act_srow == act_b - 1'b1);

        in_clip = (act_dcol >= $signed(DCOORD_W'(clip_left_reg))) &&
                  (act_dcol <  $signed(DCOORD_W'(clip_right_reg))) &&
                  (act_drow >= $signed(DCOORD_W'(clip_top_reg))) &&
                  (act_drow <  $signed(DCOORD_W'(clip_bottom_reg)));
        we      = active && in_clip && (item.data.pixel != transparent_reg);

        s1_next.src_row = active ? act_srow : '0;
        s1_next.src_col = active ? act_scol : '0;
        s1_next.dst_row = we ? act_drow[COORD_BITS-1:0] : '0;
        s1_next.dst_col = we ? act_dcol[COORD_BITS-1:0] : '0;
        s1_next.we      = we;
        s1_next.pix     = we ? item.data.pixel : '0;
        s1_next.last    = (start && empty) || (active && col_end && row_end);

        // next walk state
        mode_next       = act_mode;
        rect_l_next     = act_l;
        rect_t_next     = act_t;
        rect_r_next     = act_r;
        rect_b_next     = act_b;
        origin_col_next = act_origin;
        src_col_next    = act_scol;
        src_row_next    = act_srow;
        dst_col_next    = act_dcol;
        dst_row_next    = act_drow;
        busy_next       = active;
        if (active)
        begin
            if (col_end)
            begin
                if (row_end)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    src_col_next = hmir ? act_r - 1'b1 : {1'b0, act_l};
                    src_row_next = vmir ? act_srow - 1'b1 : act_srow + 1'b1;
                    dst_col_next = act_origin;
                    dst_row_next = act_drow + 1'b1;
                end
            end
            else
            begin
                src_col_next = hmir ? act_scol - 1'b1 : act_scol + 1'b1;
                dst_col_next = act_dcol + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_col_reg <= '0;
            dst_col_reg    <= '0;
            dst_row_reg    <= '0;
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            rect_l_reg     <= '0;
            rect_t_reg     <= '0;
            rect_r_reg     <= '0;
            rect_b_reg     <= '0;
            mode_reg       <= '0;
            busy_reg       <= 1'b0;
        end
        else if (item_fire)
        begin
            origin_col_reg <= origin_col_next;
            dst_col_reg    <= dst_col_next;
            dst_row_reg    <= dst_row_next;
            src_col_reg    <= src_col_next;
            src_row_reg    <= src_row_next;
            rect_l_reg     <= rect_l_next;
            rect_t_reg     <= rect_t_next;
            rect_r_reg     <= rect_r_next;
            rect_b_reg     <= rect_b_next;
            mode_reg       <= mode_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
            s1_reg <= s1_next;
    end

    // ---------------- stage 2: linear indices ----------------
    always_comb
    begin
        sprod = s1_reg.src_row * source_width_reg;
        dprod = s1_reg.dst_row * dest_width_reg;
        sidx  = sprod + {{COORD_BITS{1'b0}}, s1_reg.src_col};
        didx  = dprod + {{COORD_BITS{1'b0}}, s1_reg.dst_col};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (res_load && s1_valid_reg)
        begin
            res_reg.source_index <= sidx[INDEX_W-1:0];
            res_reg.dest_index   <= s1_reg.we ? didx[INDEX_W-1:0] : '0;
            res_reg.write_enable <= s1_reg.we;
            res_reg.pixel_out    <= s1_reg.pix;
            res_reg.last         <= s1_reg.last;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

endmodule

### rtl/cmcb_checker.sv
// ----------------------------------------------------------------------------
// cmcb_checker
// Port-level checks on the blitter, bound to the top level.
// ----------------------------------------------------------------------------
module cmcb_checker
    import cmcb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_ready,
    input logic      res_valid,
    input logic      res_ready,
    input cmcb_out_t res_data
);

    logic item_fire;

    assign item_fire = item_valid && item_ready;

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // no write means no address and no data
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.write_enable |->
            res_data.dest_index == '0 && res_data.pixel_out == '0)
        else $error("dest_index or pixel_out set without write");

    // a fresh result traces back to an earlier request
    a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !$past(res_valid) |-> $past(item_fire, 2))
        else $error("result without a matching request");

    // a draining sink never blocks new requests
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> item_ready)
        else $error("request stalled while results drain");

endmodule

bind clipped_mirrored_colorkey_blit cmcb_checker u_cmcb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_data   (result.data)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clipped, mirrored colour-key blitter. A request
// queue feeds a valid/ready driver; each accepted request is run through a
// behavioural model of the pixel walk, whose prediction is queued and compared
// field by field with the results. Phases cover several clip, pitch and key
// settings written over APB, with random source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import cmcb_pkg::*;

    localparam int REQ_W          = $bits(cmcb_in_t);
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_REQS     = 220;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    cmcb_in_if  in_ch ();
    cmcb_out_if out_ch ();

    clipped_mirrored_colorkey_blit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (in_ch),
        .result  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // register shadows
    logic [LCOORD_W-1:0]   cl_left;
    logic [LCOORD_W-1:0]   cl_top;
    logic [COORD_BITS-1:0] cl_right;
    logic [COORD_BITS-1:0] cl_bottom;
    logic [COORD_BITS-1:0] src_pitch;
    logic [COORD_BITS-1:0] dst_pitch;
    logic [PIXEL_W-1:0]    key_colour;

    // walk state
    longint      org_col;
    longint      dcol;
    longint      drow;
    longint      scol;
    longint      srow;
    longint      rl;
    longint      rt;
    longint      rr;
    longint      rb;
    logic [1:0]  walk_mode;
    bit          walking;

    cmcb_in_t    req_queue[$];
    cmcb_out_t   expected_pixels[$];
    int          queued;
    int          err_count;
    int          idle_cycles;
    int          result_count;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    bit          req_taken;

    task automatic report_mismatch(input string msg);
        if (err_count < 50)
            $display("[%0t] result %0d: %s", $time, result_count, msg);
        err_count++;
    endtask

    function automatic cmcb_out_t blit_step(input cmcb_in_t it);
        cmcb_out_t r;
        bit        hm;
        bit        vm;
        bit        col_end;
        bit        row_end;
        bit        wr;
        longint    sidx;
        longint    didx;
        r = '0;
        if (it.start_req)
        begin
            rl        = longint'(it.src_left);
            rt        = longint'(it.src_top);
            rr        = longint'(it.src_right);
            rb        = longint'(it.src_bottom);
            walk_mode = it.mirror_mode;
            org_col   = longint'($signed(it.dest_x));
            dcol      = org_col;
            drow      = longint'($signed(it.dest_y));
            if (rr <= rl || rb <= rt)
            begin
                walking = 1'b0;
                r.last  = 1'b1;
                return r;
            end
            scol    = walk_mode[MIRROR_H_BIT] ? rr - 1 : rl;
            srow    = walk_mode[MIRROR_V_BIT] ? rb - 1 : rt;
            walking = 1'b1;
        end
        if (!walking)
            return r;

        hm   = walk_mode[MIRROR_H_BIT];
        vm   = walk_mode[MIRROR_V_BIT];
        sidx = srow * longint'(src_pitch) + scol;
        didx = 0;
        wr   = dcol >= longint'(cl_left) && dcol < longint'(cl_right) &&
               drow >= longint'(cl_top) && drow < longint'(cl_bottom) &&
               it.pixel != key_colour;
        if (wr)
            didx = drow * longint'(dst_pitch) + dcol;
        col_end = hm ? (scol == rl) : (scol == rr - 1);
        row_end = vm ? (srow == rt) : (srow == rb - 1);

        r.source_index = INDEX_W'(sidx);
        r.dest_index   = INDEX_W'(didx);
        r.write_enable = wr;
        r.pixel_out    = wr ? it.pixel : '0;
        r.last         = col_end && row_end;

        if (col_end)
        begin
            if (row_end)
            begin
                walking = 1'b0;
            end
            else
            begin
                scol = hm ? rr - 1 : rl;
                srow = vm ? srow - 1 : srow + 1;
                dcol = org_col;
                drow = drow + 1;
            end
        end
        else
        begin
            scol = hm ? scol - 1 : scol + 1;
            dcol = dcol + 1;
        end
        return r;
    endfunction

    // ---- stimulus helpers ----
    function automatic cmcb_in_t any_req();
        cmcb_in_t r;
        r = REQ_W'({$urandom, $urandom, $urandom});
        r.start_req = 1'b0;
        return r;
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 25)
            return key_colour;
        if (k < 32)
            return 8'hFF;
        if (k < 38)
            return 8'h00;
        return PIXEL_W'($urandom_range(255));
    endfunction

    task automatic push_blit(input int dx, input int dy, input int l, input int t,
                             input int rgt, input int btm, input logic [1:0] mode,
                             input int cut);
        int       n;
        cmcb_in_t it;
        n = (rgt > l && btm > t) ? (rgt - l) * (btm - t) : 1;
        if (cut > 0 && cut < n)
            n = cut;
        for (int i = 0; i < n; i++)
        begin
            it = any_req();
            if (i == 0)
            begin
                it.start_req   = 1'b1;
                it.dest_x      = dx[COORD_BITS-1:0];
                it.dest_y      = dy[COORD_BITS-1:0];
                it.src_left    = l[LCOORD_W-1:0];
                it.src_top     = t[LCOORD_W-1:0];
                it.src_right   = rgt[COORD_BITS-1:0];
                it.src_bottom  = btm[COORD_BITS-1:0];
                it.mirror_mode = mode;
            end
            it.pixel = pick_pixel();
            req_queue.push_back(it);
        end
        queued += n;
    endtask

    task automatic queue_random_blit(output bit left_open);
        int w;
        int h;
        int l;
        int t;
        int rgt;
        int btm;
        int dx;
        int dy;
        int n;
        int cut;
        w   = ($urandom_range(9) == 0) ? int'($urandom_range(7, 24)) : int'($urandom_range(1, 6));
        h   = $urandom_range(1, 5);
        l   = $urandom_range(0, 2048 - w);
        t   = $urandom_range(0, 2048 - h);
        rgt = l + w;
        btm = t + h;
        if ($urandom_range(11) == 0)
        begin
            if ($urandom_range(1))
                rgt = $urandom_range(0, l);
            else
                btm = $urandom_range(0, t);
        end
        if ($urandom_range(3) == 0)
        begin
            dx = int'($urandom_range(0, 4095)) - 2048;
            dy = int'($urandom_range(0, 4095)) - 2048;
        end
        else
        begin
            dx = int'(cl_left) - 6 +
                 int'($urandom_range(0, (cl_right > cl_left ? cl_right - cl_left : 0) + 8));
            dy = int'(cl_top) - 5 +
                 int'($urandom_range(0, (cl_bottom > cl_top ? cl_bottom - cl_top : 0) + 6));
        end
        n   = (rgt > l && btm > t) ? w * h : 1;
        cut = 0;
        if (n > 1 && $urandom_range(9) == 0)
            cut = $urandom_range(1, n - 1);
        push_blit(dx, dy, l, t, rgt, btm, 2'($urandom_range(3)), cut);
        left_open = (cut != 0);
    endtask

    // ---- APB ----
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CLIP_LEFT:    cl_left    = value[LCOORD_W-1:0];
            REG_CLIP_TOP:     cl_top     = value[LCOORD_W-1:0];
            REG_CLIP_RIGHT:   cl_right   = value[COORD_BITS-1:0];
            REG_CLIP_BOTTOM:  cl_bottom  = value[COORD_BITS-1:0];
            REG_SOURCE_WIDTH: src_pitch  = value[COORD_BITS-1:0];
            REG_DEST_WIDTH:   dst_pitch  = value[COORD_BITS-1:0];
            REG_TRANSPARENT:  key_colour = value[PIXEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned l, input int unsigned t, input int unsigned r,
                              input int unsigned b, input int unsigned sp,
                              input int unsigned dp, input int unsigned k);
        write_reg(REG_CLIP_LEFT, l);
        write_reg(REG_CLIP_TOP, t);
        write_reg(REG_CLIP_RIGHT, r);
        write_reg(REG_CLIP_BOTTOM, b);
        write_reg(REG_SOURCE_WIDTH, sp);
        write_reg(REG_DEST_WIDTH, dp);
        write_reg(REG_TRANSPARENT, k);
    endtask

    task automatic wait_drained();
        do @(negedge clk); while (req_queue.size() != 0);
        do @(negedge clk); while (in_ch.valid || expected_pixels.size() != 0);
    endtask

    // ---- request driver ----
    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || req_taken))
        begin
            if (req_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= req_queue.pop_front();
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ---- result sink ----
    always @(negedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // ---- monitor ----
    always @(posedge clk)
    begin
        cmcb_out_t want;
        cmcb_out_t got;
        req_taken <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_pixels.push_back(blit_step(in_ch.data));
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.source_index !== want.source_index)
                    report_mismatch($sformatf("source_index %0h, want %0h",
                                              got.source_index, want.source_index));
                if (got.dest_index !== want.dest_index)
                    report_mismatch($sformatf("dest_index %0h, want %0h",
                                              got.dest_index, want.dest_index));
                if (got.write_enable !== want.write_enable)
                    report_mismatch($sformatf("write_enable %b, want %b",
                                              got.write_enable, want.write_enable));
                if (got.pixel_out !== want.pixel_out)
                    report_mismatch($sformatf("pixel_out %0h, want %0h",
                                              got.pixel_out, want.pixel_out));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
            result_count++;
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---- sequencer ----
    initial
    begin
        bit open;
        int l;
        int t;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        out_ch.ready  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_taken     = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        err_count     = 0;
        idle_cycles   = 0;
        result_count  = 0;
        queued        = 0;
        cl_left       = CLIP_LEFT_RST;
        cl_top        = CLIP_TOP_RST;
        cl_right      = CLIP_RIGHT_RST;
        cl_bottom     = CLIP_BOTTOM_RST;
        src_pitch     = SOURCE_WIDTH_RST;
        dst_pitch     = DEST_WIDTH_RST;
        key_colour    = TRANSPARENT_RST;
        org_col = 0; dcol = 0; drow = 0; scol = 0; srow = 0;
        rl = 0; rt = 0; rr = 0; rb = 0;
        walk_mode = '0;
        walking   = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings
        req_queue.push_back(any_req());
        push_blit(10, 10, 5, 3, 5, 9, 2'd0, 0);            // empty, no width
        push_blit(10, 10, 5, 9, 7, 3, 2'd2, 0);            // empty, no height
        push_blit(318, 198, 0, 0, 2, 2, 2'd0, 0);          // reaches the right and bottom clip edges
        push_blit(-1, -1, 7, 4, 9, 6, 2'd1, 0);            // clipped left and top
        push_blit(0, 199, 100, 20, 101, 23, 2'd2, 0);
        push_blit(2047, 0, 2046, 2046, 2048, 2048, 2'd3, 0);
        push_blit(5, 5, 0, 0, 3, 1, 2'd0, 1);              // abandoned by restart
        push_blit(-2048, 2047, 0, 0, 1, 1, 2'd0, 0);
        req_queue.push_back(any_req());
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config(0, 0, 2048, 2048, 2048, 2048, 255);
                1: set_config(2047, 2047, 0, 0, 2047, 1, 0);
                2: set_config(10, 5, 40, 30, 1, 2047, $urandom_range(255));
                default:
                begin
                    l = $urandom_range(0, 400);
                    t = $urandom_range(0, 300);
                    set_config(l, t, l + $urandom_range(0, 400), t + $urandom_range(0, 300),
                               $urandom_range(1, 2048), $urandom_range(1, 2048),
                               $urandom_range(255));
                end
            endcase
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 51; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 51; end
                default: begin src_idle_pct = 29; snk_stall_pct = 29; end
            endcase
            queued = 0;
            open   = 1'b0;
            // runs past column 2047
            push_blit(2044, int'(cl_top), 0, 0, 8, 2, 2'($urandom_range(3)), 0);
            if (p == 3)
                push_blit(int'(cl_left), int'(cl_top), 1800, 5, 2048, 6, 2'd1, 0);
            while (queued < PHASE_REQS)
            begin
                if ($urandom_range(99) < 6)
                    req_queue.push_back(any_req());
                else
                    queue_random_blit(open);
            end
            if (open)
                push_blit(0, 0, 3, 3, 4, 4, 2'd0, 0);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch("results still outstanding at end of run");
        if (err_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### clipped_mirrored_colorkey_blit.f
rtl/cmcb_pkg.sv
rtl/cmcb_if.sv
rtl/clipped_mirrored_colorkey_blit.sv
rtl/cmcb_checker.sv
tb/tb_top.sv
